@@ rtl/rcdx_pkg.sv @@
package rcdx_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h0F;

    // flag bits kept from the flags byte: ch17, ch18, frame lost, failsafe
    localparam int FLAG_MSB = 7;
    localparam int FLAG_LSB = 4;

    localparam int CMD_DEPTH = 2;

    // frame command handed from the front to the back
    typedef struct packed {
        logic       err;
        logic       bank;
        logic [3:0] flags;
    } cmd_t;

    // back tells the front that a store bank is free again
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

    // what the back is reading right now
    typedef struct packed {
        logic active;
        logic bank;
    } back_stat_t;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_HOLD  = 3'b100
    } back_state_t;

endpackage

@@ rtl/rcdx_ram.sv @@
module rcdx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rcdx_cmd_fifo.sv @@
module rcdx_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rcdx_pkg::cmd_t push_cmd,
    input  logic          pop,
    output rcdx_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);

    localparam int CNT_W = $clog2(rcdx_pkg::CMD_DEPTH + 1);
    localparam int PTR_W = $clog2(rcdx_pkg::CMD_DEPTH);

    rcdx_pkg::cmd_t   slot_reg [rcdx_pkg::CMD_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_next;

    assign full  = (cnt_reg == CNT_W'(rcdx_pkg::CMD_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
        end
        else if (pop && !push)
        begin
            cnt_next = CNT_W'(cnt_reg - CNT_W'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ rtl/rcdx_front.sv @@
module rcdx_front #(
    parameter int NUM_CHANNELS = 16,
    parameter int CH_W         = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        rx_byte,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  logic              cmd_full,
    output logic              cmd_push,
    output rcdx_pkg::cmd_t    cmd,
    input  rcdx_pkg::bank_rel_t rel,
    output logic              wr_en,
    output logic [CH_W:0]     wr_addr,
    output logic [15:0]       wr_data
);

    localparam int POS_W     = $clog2(2 * NUM_CHANNELS + 2);
    localparam int FLAG_POS  = 2 * NUM_CHANNELS;
    localparam int CHECK_POS = 2 * NUM_CHANNELS + 1;

    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       hi_reg, hi_next;
    logic [3:0]       flags_reg, flags_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;

    logic is_chan;
    logic is_check;
    logic accept;

    assign is_chan  = in_frame_reg && (pos_reg < POS_W'(FLAG_POS));
    assign is_check = in_frame_reg && (pos_reg == POS_W'(CHECK_POS));

    // hold a low channel byte while its bank is still being read out,
    // and the check byte while the command queue has no room
    assign byte_stall = (is_chan && pos_reg[0] && busy_reg[bank_reg])
                     || (is_check && cmd_full);
    assign accept = byte_valid && !byte_stall;

    assign wr_en   = accept && is_chan && pos_reg[0];
    assign wr_addr = {bank_reg, pos_reg[CH_W:1]};
    assign wr_data = {hi_reg, rx_byte};

    assign cmd_push   = accept && is_check;
    assign cmd.err    = (rx_byte != xor_reg);
    assign cmd.bank   = bank_reg;
    assign cmd.flags  = cmd.err ? 4'b0000 : flags_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        xor_next      = xor_reg;
        hi_next       = hi_reg;
        flags_next    = flags_reg;
        bank_next     = bank_reg;
        busy_next     = busy_reg;

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == rcdx_pkg::SYNC_BYTE)
                begin
                    in_frame_next = 1'b1;
                    pos_next      = '0;
                    xor_next      = '0;
                end
            end
            else if (is_check)
            begin
                in_frame_next = 1'b0;
                pos_next      = '0;
                if (!cmd.err)
                begin
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = ~bank_reg;
                end
            end
            else
            begin
                if (is_chan && !pos_reg[0])
                begin
                    hi_next = rx_byte;
                end
                if (!is_chan)
                begin
                    flags_next = rx_byte[rcdx_pkg::FLAG_MSB:rcdx_pkg::FLAG_LSB];
                end
                xor_next = xor_reg ^ rx_byte;
                pos_next = POS_W'(pos_reg + POS_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            xor_reg      <= '0;
            hi_reg       <= '0;
            flags_reg    <= '0;
            bank_reg     <= 1'b0;
            busy_reg     <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            xor_reg      <= xor_next;
            hi_reg       <= hi_next;
            flags_reg    <= flags_next;
            bank_reg     <= bank_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

@@ rtl/rcdx_back.sv @@
module rcdx_back #(
    parameter int NUM_CHANNELS = 16,
    parameter int CH_W         = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_empty,
    input  rcdx_pkg::cmd_t       head,
    output logic                 cmd_pop,
    output logic [CH_W:0]        rd_addr,
    input  logic [15:0]          rd_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 status,
    output logic [3:0]           channel_index,
    output logic [15:0]          channel_value,
    output logic                 aux_ch17,
    output logic                 aux_ch18,
    output logic                 link_lost,
    output logic                 failsafe,
    output logic                 last,
    output rcdx_pkg::bank_rel_t  rel,
    output rcdx_pkg::back_stat_t stat
);

    localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);

    rcdx_pkg::back_state_t state_reg, state_next;
    logic [CH_W-1:0]       idx_reg, idx_next;
    rcdx_pkg::cmd_t        cmd_reg, cmd_next;
    logic                  valid_reg, valid_next;
    logic                  status_reg, status_next;
    logic [3:0]            index_reg, index_next;
    logic [15:0]           value_reg, value_next;
    logic [3:0]            flags_reg, flags_next;
    logic                  last_reg, last_next;

    logic            out_beat;
    logic [CH_W-1:0] idx_inc;

    assign out_beat = valid_reg && !result_stall;
    assign idx_inc  = CH_W'(idx_reg + CH_W'(1));

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        valid_next  = out_beat ? 1'b0 : valid_reg;
        status_next = status_reg;
        index_next  = index_reg;
        value_next  = value_reg;
        flags_next  = flags_reg;
        last_next   = last_reg;
        cmd_pop     = 1'b0;
        rd_addr     = {cmd_reg.bank, idx_reg};
        rel         = '0;

        case (state_reg)
            rcdx_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = head;
                    idx_next = '0;
                    if (head.err)
                    begin
                        valid_next  = 1'b1;
                        status_next = 1'b1;
                        index_next  = '0;
                        value_next  = '0;
                        flags_next  = '0;
                        last_next   = 1'b1;
                        state_next  = rcdx_pkg::B_HOLD;
                    end
                    else
                    begin
                        rd_addr    = {head.bank, {CH_W{1'b0}}};
                        state_next = rcdx_pkg::B_FETCH;
                    end
                end
            end
            rcdx_pkg::B_FETCH:
            begin
                valid_next  = 1'b1;
                status_next = 1'b0;
                index_next  = 4'(idx_reg);
                value_next  = rd_data;
                flags_next  = cmd_reg.flags;
                last_next   = (idx_reg == LAST_IDX);
                state_next  = rcdx_pkg::B_HOLD;
            end
            rcdx_pkg::B_HOLD:
            begin
                if (out_beat)
                begin
                    if (cmd_reg.err || idx_reg == LAST_IDX)
                    begin
                        rel.valid  = !cmd_reg.err;
                        rel.bank   = cmd_reg.bank;
                        state_next = rcdx_pkg::B_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_inc;
                        rd_addr    = {cmd_reg.bank, idx_inc};
                        state_next = rcdx_pkg::B_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = rcdx_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcdx_pkg::B_IDLE;
            idx_reg   <= '0;
            cmd_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cmd_reg   <= cmd_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        flags_reg  <= flags_next;
        last_reg   <= last_next;
    end

    assign result_valid  = valid_reg;
    assign status        = status_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign aux_ch17      = flags_reg[3];
    assign aux_ch18      = flags_reg[2];
    assign link_lost     = flags_reg[1];
    assign failsafe      = flags_reg[0];
    assign last          = last_reg;

    assign stat.active = (state_reg != rcdx_pkg::B_IDLE) && !cmd_reg.err;
    assign stat.bank   = cmd_reg.bank;

endmodule

@@ rtl/rc_frame_deframer_xor_check_unit.sv @@
// Input: one byte per cycle; a channel byte stalls only while its store bank is still
//   being read out, the check byte only while the two-entry command queue is full.
// Output: an error result passes the command queue, then the output register; channel
//   results pass the queue, store read and output register, one channel at a time.
// Reset (rst_n, async, low): hunting, queue and output empty; channel store not cleared.
module rc_frame_deframer_xor_check_unit #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        byte_valid,
    output logic        byte_stall,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        status,
    output logic [3:0]  channel_index,
    output logic [15:0] channel_value,
    output logic        aux_ch17,
    output logic        aux_ch18,
    output logic        link_lost,
    output logic        failsafe,
    output logic        last
);

    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RAM_DEPTH = 2 * (2 ** CH_W);

    logic                 cmd_push;
    logic                 cmd_pop;
    logic                 cmd_full;
    logic                 cmd_empty;
    rcdx_pkg::cmd_t       push_cmd;
    rcdx_pkg::cmd_t       head_cmd;
    rcdx_pkg::bank_rel_t  rel;
    rcdx_pkg::back_stat_t stat;
    logic                 wr_en;
    logic [CH_W:0]        wr_addr;
    logic [15:0]          wr_data;
    logic [CH_W:0]        rd_addr;
    logic [15:0]          rd_data;

    rcdx_front #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .CH_W        (CH_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd),
        .rel       (rel),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    rcdx_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .push_cmd(push_cmd),
        .pop     (cmd_pop),
        .head    (head_cmd),
        .full    (cmd_full),
        .empty   (cmd_empty)
    );

    rcdx_ram #(
        .WIDTH(16),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    rcdx_back #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .CH_W        (CH_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_empty    (cmd_empty),
        .head         (head_cmd),
        .cmd_pop      (cmd_pop),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .channel_index(channel_index),
        .channel_value(channel_value),
        .aux_ch17     (aux_ch17),
        .aux_ch18     (aux_ch18),
        .link_lost    (link_lost),
        .failsafe     (failsafe),
        .last         (last),
        .rel          (rel),
        .stat         (stat)
    );

    // front never writes the bank the back is reading
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && stat.active |-> wr_addr[CH_W] != stat.bank)
        else $error("store write into bank under readout");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status |-> last && channel_index == 4'd0 && channel_value == 16'd0)
        else $error("malformed error beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !status && last |-> channel_index == 4'(NUM_CHANNELS - 1))
        else $error("last flag on wrong channel");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam int NCH = 16;
    localparam int FLAGS_POS = 2 * NCH;
    localparam logic RES_OK = 1'b0;
    localparam logic RES_CHECK_ERR = 1'b1;

    typedef struct packed {
        logic        status;
        logic [3:0]  idx;
        logic [15:0] value;
        logic [3:0]  flags;
        logic        last;
    } chan_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        status;
    logic [3:0]  channel_index;
    logic [15:0] channel_value;
    logic        aux_ch17;
    logic        aux_ch18;
    logic        link_lost;
    logic        failsafe;
    logic        last;

    logic [7:0]   tx_bytes[$];
    chan_result_t frame_results_due[$];
    int           send_idle_pct = 0;
    int           rcv_idle_pct = 0;
    int           errors = 0;

    // deframer image
    logic        in_sync = 1'b0;
    logic [5:0]  byte_pos = '0;
    logic [7:0]  xor_acc = '0;
    logic [7:0]  hi_byte = '0;
    logic [15:0] ch_words[NCH];
    logic [3:0]  flag_bits = '0;

    rc_frame_deframer_xor_check_unit #(
        .NUM_CHANNELS(NCH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .channel_index(channel_index),
        .channel_value(channel_value),
        .aux_ch17     (aux_ch17),
        .aux_ch18     (aux_ch18),
        .link_lost    (link_lost),
        .failsafe     (failsafe),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic deframe_byte(input logic [7:0] b);
        chan_result_t r;
        int i;
        if (!in_sync)
        begin
            if (b == rcdx_pkg::SYNC_BYTE)
            begin
                in_sync = 1'b1;
                byte_pos = '0;
                xor_acc = '0;
            end
        end
        else if (byte_pos < FLAGS_POS)
        begin
            if (!byte_pos[0])
                hi_byte = b;
            else
                ch_words[byte_pos >> 1] = {hi_byte, b};
            xor_acc ^= b;
            byte_pos++;
        end
        else if (byte_pos == FLAGS_POS)
        begin
            flag_bits = b[rcdx_pkg::FLAG_MSB:rcdx_pkg::FLAG_LSB];
            xor_acc ^= b;
            byte_pos++;
        end
        else
        begin
            in_sync = 1'b0;
            byte_pos = '0;
            if (b != xor_acc)
            begin
                r = '{status: RES_CHECK_ERR, idx: 4'd0, value: 16'd0, flags: 4'd0, last: 1'b1};
                frame_results_due.push_back(r);
            end
            else
            begin
                for (i = 0; i < NCH; i++)
                begin
                    r.status = RES_OK;
                    r.idx = i[3:0];
                    r.value = ch_words[i];
                    r.flags = flag_bits;
                    r.last = (i == NCH - 1);
                    frame_results_due.push_back(r);
                end
            end
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                deframe_byte(rx_byte);
            if (!byte_valid || !byte_stall)
            begin
                if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    rx_byte <= tx_bytes.pop_front();
                    byte_valid <= 1'b1;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin : mon
        chan_result_t r;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (frame_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual idx %0h value %0h",
                             $time, channel_index, channel_value);
                    errors++;
                end
                else
                begin
                    r = frame_results_due.pop_front();
                    check_field("status", r.status, status);
                    check_field("channel_index", r.idx, channel_index);
                    check_field("channel_value", r.value, channel_value);
                    check_field("aux_ch17", r.flags[3], aux_ch17);
                    check_field("aux_ch18", r.flags[2], aux_ch18);
                    check_field("link_lost", r.flags[1], link_lost);
                    check_field("failsafe", r.flags[0], failsafe);
                    check_field("last", r.last, last);
                end
            end
            result_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // extremes: zero, all ones, start byte as data, top and bottom bits
    task automatic push_frame(input bit extremes, input logic [7:0] flags, input bit corrupt);
        logic [7:0]  x;
        logic [15:0] w;
        int i;
        x = '0;
        tx_bytes.push_back(rcdx_pkg::SYNC_BYTE);
        for (i = 0; i < NCH; i++)
        begin
            if (extremes)
            begin
                case (i % 4)
                    0: w = 16'h0000;
                    1: w = 16'hFFFF;
                    2: w = {rcdx_pkg::SYNC_BYTE, rcdx_pkg::SYNC_BYTE};
                    default: w = 16'h8001;
                endcase
            end
            else
            begin
                case ($urandom_range(7))
                    0: w = 16'h0000;
                    1: w = 16'hFFFF;
                    default: w = 16'($urandom_range(16'hFFFF));
                endcase
            end
            tx_bytes.push_back(w[15:8]);
            tx_bytes.push_back(w[7:0]);
            x ^= w[15:8] ^ w[7:0];
        end
        tx_bytes.push_back(flags);
        x ^= flags;
        if (corrupt)
            x ^= 8'($urandom_range(1, 255));
        tx_bytes.push_back(x);
    endtask

    task automatic drain();
        while (tx_bytes.size() != 0 || byte_valid || frame_results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_frames(input int nframes);
        int f;
        int k;
        for (f = 0; f < nframes; f++)
        begin
            repeat ($urandom_range(3))
                tx_bytes.push_back(8'($urandom_range(255)));
            // truncated frame: the next frame start gets eaten as data
            if ($urandom_range(5) == 0)
            begin
                tx_bytes.push_back(rcdx_pkg::SYNC_BYTE);
                for (k = $urandom_range(1, 12); k > 0; k--)
                    tx_bytes.push_back(8'($urandom_range(255)));
            end
            push_frame(1'b0, 8'($urandom_range(255)), $urandom_range(6) == 0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        rcv_idle_pct = 85;

        // hunting noise, then good frame, bad check, good frame with low flag bits only
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h0E);
        tx_bytes.push_back(8'h10);
        push_frame(1'b1, 8'hF0, 1'b0);
        push_frame(1'b1, 8'hA5, 1'b1);
        push_frame(1'b0, 8'h0F, 1'b0);
        drain();

        send_idle_pct = 85;
        rcv_idle_pct = 12;
        random_frames(1);
        drain();

        send_idle_pct = 0;
        rcv_idle_pct = 0;
        random_frames(1);
        drain();

        repeat (20) @(posedge clk);
        if (frame_results_due.size() != 0)
        begin
            $display("%0t: %0d results expected but never seen", $time,
                     frame_results_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
